>>> hdl/bhpq_pkg.sv
`default_nettype none

package bhpq_pkg;

  localparam int unsigned DEPTH_DEF    = 64;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned TAG_BITS_DEF = 32;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_EXTRACT = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP_RD   = 8'b0000_0010,
    S_UP_CMP  = 8'b0000_0100,
    S_DN_LAST = 8'b0000_1000,
    S_DN_LOAD = 8'b0001_0000,
    S_DN_RDL  = 8'b0010_0000,
    S_DN_RDR  = 8'b0100_0000,
    S_DN_CMP  = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

>>> hdl/bhpq_ram.sv
`default_nettype none

module bhpq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/binary_heap_priority_queue.sv
`default_nettype none

// channel   dir  tdata fields (low bit up)            notes
// s_axis    in   opcode, key, tag                      one request per transaction
// m_axis    out  top_key, top_tag, status, fill        one result per request
// cfg       in   min_order                             write enable, no read-back
//
// result in the cycle after acceptance for peek, rejected insert, extract from an empty
// heap or extract of the last entry
// insert: per level of sift-up, read the parent then compare (single ram read port)
// extract: load the last entry, then per level read left child, right child and compare
// reset clears fill count and control state, selects min order; ram contents never cleared
// a new request is taken only when the block is idle and the result register is free

module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int unsigned DEPTH    = bhpq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = bhpq_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = bhpq_pkg::TAG_BITS_DEF,
  localparam int unsigned CW      = $clog2(DEPTH + 1),
  localparam int unsigned IN_W    = 2 + KEY_BITS + TAG_BITS,
  localparam int unsigned IN_PAD  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W   = KEY_BITS + TAG_BITS + 2 + CW,
  localparam int unsigned OUT_PAD = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [IN_PAD-1:0]  s_axis_tdata,   // opcode, key, tag
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [OUT_PAD-1:0] m_axis_tdata    // top_key, top_tag, status, fill
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned EW  = KEY_BITS + TAG_BITS;
  localparam int unsigned CIW = AW + 2;

  function automatic logic ranks(input logic mo, input logic [KEY_BITS-1:0] a,
                                 input logic [KEY_BITS-1:0] b);
    return mo ? (a < b) : (a > b);
  endfunction

  logic [1:0]          in_op;
  logic [KEY_BITS-1:0] in_key;
  logic [TAG_BITS-1:0] in_tag;
  logic                in_acc;

  assign in_op  = s_axis_tdata[1:0];
  assign in_key = s_axis_tdata[2 +: KEY_BITS];
  assign in_tag = s_axis_tdata[2 + KEY_BITS +: TAG_BITS];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic                min_order_q;
  logic                out_valid_q, out_valid_d;
  logic                ins_q, ins_d;
  logic                place_q, place_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [KEY_BITS-1:0] x_key_q, x_key_d;
  logic [TAG_BITS-1:0] x_tag_q, x_tag_d;
  logic [KEY_BITS-1:0] l_key_q, l_key_d;
  logic [TAG_BITS-1:0] l_tag_q, l_tag_d;
  logic                rv_q, rv_d;
  logic [KEY_BITS-1:0] root_key_q;
  logic [TAG_BITS-1:0] root_tag_q;
  logic [KEY_BITS-1:0] o_key_q, o_key_d;
  logic [TAG_BITS-1:0] o_tag_q, o_tag_d;
  logic [1:0]          o_status_q, o_status_d;
  logic [CW-1:0]       o_fill_q, o_fill_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [EW-1:0]       ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [TAG_BITS-1:0] rd_tag;

  logic [AW-1:0]       par_idx;
  logic [CIW-1:0]      l_idx, r_idx;
  logic                l_ok, r_ok;
  logic                pick_r;
  logic [KEY_BITS-1:0] c_key;
  logic [TAG_BITS-1:0] c_tag;
  logic [AW-1:0]       c_idx;

  assign rd_key  = ram_rdata[KEY_BITS-1:0];
  assign rd_tag  = ram_rdata[KEY_BITS +: TAG_BITS];
  assign par_idx = (pos_q - AW'(1)) >> 1;
  assign l_idx   = {1'b0, pos_q, 1'b1};
  assign r_idx   = l_idx + CIW'(1);
  assign l_ok    = l_idx < CIW'(count_q);
  assign r_ok    = r_idx < CIW'(count_q);
  assign pick_r  = rv_q && ranks(min_order_q, rd_key, l_key_q);
  assign c_key   = pick_r ? rd_key : l_key_q;
  assign c_tag   = pick_r ? rd_tag : l_tag_q;
  assign c_idx   = pick_r ? r_idx[AW-1:0] : l_idx[AW-1:0];

  assign s_axis_tready = (state_q == S_IDLE) && !place_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ins_d       = ins_q;
    place_d     = 1'b0;
    pos_d       = pos_q;
    x_key_d     = x_key_q;
    x_tag_d     = x_tag_q;
    l_key_d     = l_key_q;
    l_tag_d     = l_tag_q;
    rv_d        = rv_q;
    o_key_d     = o_key_q;
    o_tag_d     = o_tag_q;
    o_status_d  = o_status_q;
    o_fill_d    = o_fill_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = {x_tag_q, x_key_q};
    ram_raddr   = par_idx;

    if (place_q) begin
      // drop the moving entry into the hole and publish the result
      ram_we      = 1'b1;
      out_valid_d = 1'b1;
      if (ins_q) begin
        o_key_d = (pos_q == '0) ? x_key_q : root_key_q;
        o_tag_d = (pos_q == '0) ? x_tag_q : root_tag_q;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          o_fill_d   = count_q;
          o_status_d = ST_OK;
          o_key_d    = root_key_q;
          o_tag_d    = root_tag_q;
          unique case (in_op)
            OP_INSERT: begin
              if (count_q == CW'(DEPTH)) begin
                o_status_d  = ST_FULL;
                out_valid_d = 1'b1;
              end else begin
                ins_d    = 1'b1;
                x_key_d  = in_key;
                x_tag_d  = in_tag;
                pos_d    = count_q[AW-1:0];
                count_d  = count_q + CW'(1);
                o_fill_d = count_q + CW'(1);
                if (count_q == '0) begin
                  place_d = 1'b1;
                end else begin
                  state_d = S_UP_RD;
                end
              end
            end
            OP_EXTRACT: begin
              if (count_q == '0) begin
                o_status_d  = ST_EMPTY;
                o_key_d     = '0;
                o_tag_d     = '0;
                out_valid_d = 1'b1;
              end else begin
                ins_d    = 1'b0;
                count_d  = count_q - CW'(1);
                o_fill_d = count_q - CW'(1);
                if (count_q == CW'(1)) begin
                  out_valid_d = 1'b1;
                end else begin
                  state_d = S_DN_LAST;
                end
              end
            end
            default: begin
              if (count_q == '0) begin
                o_status_d = ST_EMPTY;
                o_key_d    = '0;
                o_tag_d    = '0;
              end
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_UP_RD: begin
        ram_raddr = par_idx;
        state_d   = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (ranks(min_order_q, x_key_q, rd_key)) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_d     = par_idx;
          if (par_idx == '0) begin
            place_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_UP_RD;
          end
        end else begin
          place_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DN_LAST: begin
        ram_raddr = count_q[AW-1:0];
        state_d   = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        x_key_d = rd_key;
        x_tag_d = rd_tag;
        pos_d   = '0;
        state_d = S_DN_RDL;
      end
      S_DN_RDL: begin
        ram_raddr = l_idx[AW-1:0];
        if (l_ok) begin
          state_d = S_DN_RDR;
        end else begin
          place_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DN_RDR: begin
        l_key_d   = rd_key;
        l_tag_d   = rd_tag;
        rv_d      = r_ok;
        ram_raddr = r_idx[AW-1:0];
        state_d   = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (ranks(min_order_q, c_key, x_key_q)) begin
          ram_we    = 1'b1;
          ram_wdata = {c_tag, c_key};
          pos_d     = c_idx;
          state_d   = S_DN_RDL;
        end else begin
          place_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      min_order_q <= 1'b1;
      out_valid_q <= 1'b0;
      place_q     <= 1'b0;
      ins_q       <= 1'b0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      place_q     <= place_d;
      ins_q       <= ins_d;
      rv_q        <= rv_d;
      if (cfg_we_i) begin
        min_order_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    x_key_q    <= x_key_d;
    x_tag_q    <= x_tag_d;
    l_key_q    <= l_key_d;
    l_tag_q    <= l_tag_d;
    o_key_q    <= o_key_d;
    o_tag_q    <= o_tag_d;
    o_status_q <= o_status_d;
    o_fill_q   <= o_fill_d;
    // shadow copy of the root entry
    if (ram_we && (ram_waddr == '0)) begin
      root_key_q <= ram_wdata[KEY_BITS-1:0];
      root_tag_q <= ram_wdata[KEY_BITS +: TAG_BITS];
    end
  end

  bhpq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0 +: KEY_BITS]                  = o_key_q;
    m_axis_tdata[KEY_BITS +: TAG_BITS]           = o_tag_q;
    m_axis_tdata[KEY_BITS + TAG_BITS +: 2]       = o_status_q;
    m_axis_tdata[KEY_BITS + TAG_BITS + 2 +: CW]  = o_fill_q;
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (place_q || state_q == S_UP_CMP || state_q == S_DN_CMP))
    else $error("ram write outside a sift");

  a_result_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_fill_q == count_q))
    else $error("result fill differs from entry count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && o_status_q == ST_FULL) |-> (count_q == CW'(DEPTH)))
    else $error("full status while heap not full");

  a_accept_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (!out_valid_q || o_status_q != ST_OK || state_q == S_IDLE))
    else $error("request taken while busy");

endmodule

`default_nettype wire

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bhpq_pkg::*;

  localparam int unsigned HEAP_DEPTH    = DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned ITEM_TARGET   = 550;
  localparam int unsigned CALM_FROM     = 470;
  localparam int unsigned FILL_SPAN     = 3 * HEAP_DEPTH;
  // the spare opcode behaves as a peek
  localparam logic [1:0]  OP_PEEK_ALIAS = 2'd3;

  typedef struct {
    logic [31:0] top_key;
    logic [31:0] top_tag;
    logic [1:0]  status;
    logic [6:0]  fill;
  } heap_reply_t;

  class heap_tracker;
    bit [31:0]   key_store[HEAP_DEPTH];
    bit [31:0]   tag_store[HEAP_DEPTH];
    int unsigned held;
    bit          min_order;
    heap_reply_t awaited[$];
    int          errors;

    function new();
      held      = 0;
      min_order = 1'b1;
      errors    = 0;
    endfunction

    function bit outranks(bit [31:0] a, bit [31:0] b);
      return min_order ? (a < b) : (a > b);
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      bit [31:0] k;
      bit [31:0] t;
      k            = key_store[a];
      t            = tag_store[a];
      key_store[a] = key_store[b];
      tag_store[a] = tag_store[b];
      key_store[b] = k;
      tag_store[b] = t;
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] key, logic [31:0] tag);
      heap_reply_t r;
      int unsigned pos;
      int unsigned up;
      int unsigned left;
      int unsigned right;
      int unsigned best;
      r.top_key = '0;
      r.top_tag = '0;
      r.status  = ST_OK;
      if (op == OP_INSERT) begin
        if (held >= HEAP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key_store[held] = key;
          tag_store[held] = tag;
          pos             = held;
          held++;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (!outranks(key_store[pos], key_store[up])) break;
            swap_slots(pos, up);
            pos = up;
          end
        end
        r.top_key = key_store[0];
        r.top_tag = tag_store[0];
      end else if (op == OP_EXTRACT) begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top_key = key_store[0];
          r.top_tag = tag_store[0];
          held--;
          if (held > 0) begin
            key_store[0] = key_store[held];
            tag_store[0] = tag_store[held];
            pos          = 0;
            forever begin
              left  = 2 * pos + 1;
              right = left + 1;
              best  = pos;
              if (left < held && outranks(key_store[left], key_store[best])) best = left;
              if (right < held && outranks(key_store[right], key_store[best])) best = right;
              if (best == pos) break;
              swap_slots(pos, best);
              pos = best;
            end
          end
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.top_key = key_store[0];
          r.top_tag = tag_store[0];
        end
      end
      r.fill  = held[6:0];
      awaited = {awaited, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [79:0] beat);
      heap_reply_t got;
      heap_reply_t want;
      got.top_key = beat[31:0];
      got.top_tag = beat[63:32];
      got.status  = beat[65:64];
      got.fill    = beat[72:66];
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual key %h tag %h status %0d fill %0d",
                 $time, got.top_key, got.top_tag, got.status, got.fill);
        return;
      end
      want = awaited.pop_front();
      compare_field("top_key", want.top_key, got.top_key);
      compare_field("top_tag", want.top_tag, got.top_tag);
      compare_field("status", {30'b0, want.status}, {30'b0, got.status});
      compare_field("fill", {25'b0, want.fill}, {25'b0, got.fill});
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // opcode, key, tag
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // top_key, top_tag, status, fill

  heap_tracker tracker = new();
  bit          idling  = 1'b1;
  int unsigned sent    = 0;

  binary_heap_priority_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // result side with random stalls
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idling && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 16);
      end
    end
  end

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 15);
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [1:0] op, logic [31:0] key, logic [31:0] tag);
    int unsigned gap;
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, tag, key, op};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(op, key, tag);
    sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(bit value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.min_order = value;
  endtask

  task automatic fill_and_empty();
    while (tracker.held < HEAP_DEPTH) send_request(OP_INSERT, rand_key(), $urandom);
    repeat ($urandom_range(1, 3)) send_request(OP_INSERT, rand_key(), $urandom);
    while (tracker.held > 0) begin
      if ($urandom_range(0, 7) == 0) send_request(OP_PEEK, $urandom, $urandom);
      else send_request(OP_EXTRACT, $urandom, $urandom);
    end
    send_request(OP_EXTRACT, $urandom, $urandom);
    send_request(OP_PEEK, $urandom, $urandom);
  endtask

  task automatic mixed_burst(int unsigned count);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) send_request(OP_INSERT, rand_key(), $urandom);
      else if (pick < 16) send_request(OP_EXTRACT, $urandom, $urandom);
      else if (pick < 19) send_request(OP_PEEK, $urandom, $urandom);
      else send_request(OP_PEEK_ALIAS, $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned burst;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // min-order: empty heap, extreme keys and equal keys
    write_order(1'b1);
    send_request(OP_PEEK, 32'h0, 32'h0);
    send_request(OP_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_PEEK_ALIAS, 32'h0, 32'h0);
    send_request(OP_INSERT, 32'h0, 32'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h5, 32'hA);
    send_request(OP_INSERT, 32'h5, 32'hB);
    send_request(OP_INSERT, 32'h5, 32'hC);
    send_request(OP_PEEK, 32'h0, 32'h0);
    send_request(OP_PEEK_ALIAS, 32'h0, 32'h0);
    repeat (6) send_request(OP_EXTRACT, 32'h0, 32'h0);

    // max-order with ties
    write_order(1'b0);
    send_request(OP_INSERT, 32'h5, 32'h1);
    send_request(OP_INSERT, 32'h5, 32'h2);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h3);
    send_request(OP_INSERT, 32'h0, 32'h4);
    send_request(OP_PEEK, 32'h0, 32'h0);
    repeat (4) send_request(OP_EXTRACT, 32'h0, 32'h0);

    write_order(1'($urandom_range(0, 1)));
    fill_and_empty();
    wait_drained();

    while (sent < ITEM_TARGET) begin
      if (sent > CALM_FROM) idling = 1'b0;
      burst = $urandom_range(15, 50);
      if (burst > ITEM_TARGET - sent) burst = ITEM_TARGET - sent;
      case ($urandom_range(0, 7))
        0:       write_order(1'($urandom_range(0, 1)));
        1: begin
          if ($urandom_range(0, 2) == 0 && sent + FILL_SPAN < ITEM_TARGET) fill_and_empty();
          else mixed_burst(burst);
        end
        default: mixed_burst(burst);
      endcase
    end
    idling = 1'b0;
    wait_drained();

    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
